// File: rtl/aara_pkg.sv
// shared types, codes and helpers for the aligned address range allocator
package aara_pkg;

    localparam int CW = 52;

    localparam logic [2:0] FN_RESERVE    = 3'd0;
    localparam logic [2:0] FN_RESERVE_AT = 3'd1;
    localparam logic [2:0] FN_EXCLUDE    = 3'd2;
    localparam logic [2:0] FN_RECLAIM    = 3'd3;
    localparam logic [2:0] FN_INSPECT    = 3'd4;

    localparam logic [2:0] ST_OK          = 3'd0;
    localparam logic [2:0] ST_INVALID     = 3'd1;
    localparam logic [2:0] ST_NO_SPACE    = 3'd2;
    localparam logic [2:0] ST_NOT_FOUND   = 3'd3;
    localparam logic [2:0] ST_WRONG_OWNER = 3'd4;

    localparam logic [0:0] REG_REGION_START = 1'b0;
    localparam logic [0:0] REG_REGION_END   = 1'b1;

    typedef enum logic [1:0] {
        K_FREE,
        K_RESERVED,
        K_EXCLUDED
    } kind_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_PREP,
        S_SCAN,
        S_PASS,
        S_HRD,
        S_HCHK,
        S_RESP
    } state_t;

    typedef struct packed {
        logic [2:0]  func;
        logic [63:0] owner_id;
        logic [47:0] base_addr;
        logic [48:0] length_bytes;
        logic [48:0] align_bytes;
        logic [3:0]  handle_slot;
        logic [63:0] handle_gen;
    } in_item_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [3:0]  out_slot;
        logic [63:0] out_gen;
        logic [47:0] out_base;
        logic [48:0] out_length;
    } out_item_t;

    typedef struct packed {
        logic [63:0] owner;
        logic [47:0] base;
        logic [48:0] length;
        logic [63:0] gen;
    } slot_entry_t;

    function automatic logic [CW-1:0] align_up(input logic [CW-1:0] v,
                                               input logic [CW-1:0] a);
        return (v + a - CW'(1)) & ~(a - CW'(1));
    endfunction

endpackage

// File: rtl/aara_slot_mem.sv
// slot table memory, one write and one registered read port
module aara_slot_mem #(
    parameter int SLOTS = 16,
    localparam int AW = (SLOTS > 1) ? $clog2(SLOTS) : 1
) (
    input  logic                  clk,
    input  logic                  wr_en,
    input  logic [AW-1:0]         wr_addr,
    input  aara_pkg::slot_entry_t wr_data,
    input  logic                  rd_en,
    input  logic [AW-1:0]         rd_addr,
    output aara_pkg::slot_entry_t rd_data
);
    import aara_pkg::*;

    slot_entry_t mem [SLOTS];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// File: rtl/aligned_address_range_allocator_unit.sv
// top level of the aligned address range allocator
// one item in flight; handle ops read their slot once, reserve_at and exclude scan the table once
// reserve rescans from a new candidate after each hit, up to a pass limit: each pass reads every slot
// through the single slot memory read port, one entry per cycle
// result register lets a finished result wait while the block stays ready
// reset clears all slot kinds to free at once, next generation to one
module aligned_address_range_allocator_unit #(
    parameter int SLOTS = 16,
    parameter int ADDR_BITS = 48,
    parameter int PAGE_BYTES = 4096
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  aara_pkg::in_item_t in_item,
    output logic               out_valid,
    input  logic               out_stall,
    output aara_pkg::out_item_t out_item,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [0:0]         cfg_index,
    input  logic [48:0]        cfg_data
);
    import aara_pkg::*;

    localparam int SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int IW = $clog2(SLOTS + 1);
    localparam int PW = $clog2(SLOTS + 3);
    localparam logic [63:0] CAP64 = 64'd1 << ADDR_BITS;
    localparam logic [48:0] PAGE_M49 = 49'(PAGE_BYTES - 1);
    localparam logic [CW-1:0] PAGE_MC = CW'(PAGE_BYTES - 1);

    state_t      state_reg, state_next;
    in_item_t    item_reg, item_next;
    out_item_t   res_reg, res_next;
    out_item_t   out_reg, out_next;
    logic        out_valid_reg, out_valid_next;
    logic [47:0] start_reg;
    logic [48:0] end_reg;
    logic [CW-1:0] lim_reg, lim_next;
    logic [CW-1:0] cand_reg, cand_next;
    logic [CW-1:0] cand_end_reg, cand_end_next;
    logic [CW-1:0] nxt_reg, nxt_next;
    logic        hit_reg, hit_next;
    logic        free_found_reg, free_found_next;
    logic [SW-1:0] free_idx_reg, free_idx_next;
    logic [IW-1:0] idx_reg, idx_next;
    logic        chk_valid_reg, chk_valid_next;
    logic [SW-1:0] chk_idx_reg, chk_idx_next;
    logic [PW-1:0] pass_reg, pass_next;
    logic [63:0] gen_reg, gen_next;
    kind_t       kind_reg [SLOTS];

    logic        in_acc;
    logic        rsv_ok, hdl_ok, idle_done;
    logic [2:0]  idle_status;
    logic [CW-1:0] lim_c;
    logic        rf_ok, is_rsv, last_pass, place_ok, issue, scan_end;
    logic [8:0]  hs9, fi9;
    logic [SW-1:0] hidx;
    logic [CW-1:0] len_c, ent_end;
    kind_t       chk_kind, h_kind;
    logic        mem_wr_en, mem_rd_en;
    logic [SW-1:0] mem_rd_addr;
    slot_entry_t mem_wr_data, mem_rd_data;

    aara_slot_mem #(.SLOTS(SLOTS)) u_mem (
        .clk     (clk),
        .wr_en   (mem_wr_en),
        .wr_addr (free_idx_reg),
        .wr_data (mem_wr_data),
        .rd_en   (mem_rd_en),
        .rd_addr (mem_rd_addr),
        .rd_data (mem_rd_data)
    );

    assign in_stall  = (state_reg != S_IDLE);
    assign in_acc    = in_valid && !in_stall;
    assign cfg_ready = 1'b1;
    assign out_valid = out_valid_reg;
    assign out_item  = out_reg;

    assign lim_c = (64'(end_reg) > CAP64) ? CW'(CAP64) : CW'(end_reg);
    assign rsv_ok = (in_item.owner_id != 64'd0) && (in_item.length_bytes != 49'd0)
        && ((in_item.length_bytes & PAGE_M49) == 49'd0)
        && (in_item.align_bytes >= 49'(PAGE_BYTES))
        && ((in_item.align_bytes & (in_item.align_bytes - 49'd1)) == 49'd0);
    assign hdl_ok = (9'(in_item.handle_slot) < 9'(SLOTS)) && (in_item.handle_gen != 64'd0);

    assign len_c   = CW'(item_reg.length_bytes);
    assign is_rsv  = (item_reg.func == FN_RESERVE);
    assign rf_ok   = (cand_reg >= CW'(start_reg)) && (len_c != '0) && (cand_reg < lim_reg)
        && (len_c <= lim_reg - cand_reg) && ((cand_reg & PAGE_MC) == '0)
        && ((len_c & PAGE_MC) == '0);
    assign last_pass = (pass_reg == PW'(SLOTS + 1));
    assign place_ok  = free_found_reg && (gen_reg != 64'd0) && (gen_reg != '1);
    assign issue     = (idx_reg != IW'(SLOTS));
    assign scan_end  = !issue && !chk_valid_reg;
    assign hs9       = 9'(item_reg.handle_slot);
    assign hidx      = hs9[SW-1:0];
    assign fi9       = 9'(free_idx_reg);
    assign chk_kind  = kind_reg[chk_idx_reg];
    assign h_kind    = kind_reg[hidx];
    assign ent_end   = CW'(mem_rd_data.base) + CW'(mem_rd_data.length);

    assign mem_wr_en = (state_reg == S_PASS) && !hit_reg && place_ok;
    assign mem_wr_data.owner  = (item_reg.func == FN_EXCLUDE) ? 64'd0 : item_reg.owner_id;
    assign mem_wr_data.base   = cand_reg[47:0];
    assign mem_wr_data.length = item_reg.length_bytes;
    assign mem_wr_data.gen    = gen_reg;
    assign mem_rd_en   = ((state_reg == S_SCAN) && issue) || (state_reg == S_HRD);
    assign mem_rd_addr = (state_reg == S_HRD) ? hidx : idx_reg[SW-1:0];

    always_comb
    begin
        idle_done   = 1'b0;
        idle_status = ST_INVALID;
        case (in_item.func)
            FN_RESERVE:    idle_done = !rsv_ok;
            FN_RESERVE_AT: idle_done = (in_item.owner_id == 64'd0);
            FN_EXCLUDE:    idle_done = 1'b0;
            FN_RECLAIM, FN_INSPECT:
            begin
                idle_done   = !hdl_ok;
                idle_status = ST_NOT_FOUND;
            end
            default:       idle_done = 1'b1;
        endcase
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_acc)
                begin
                    if (idle_done)
                        state_next = S_RESP;
                    else if (in_item.func == FN_RECLAIM || in_item.func == FN_INSPECT)
                        state_next = S_HRD;
                    else
                        state_next = S_PREP;
                end
            end
            S_PREP:  state_next = rf_ok ? S_SCAN : S_RESP;
            S_SCAN:  state_next = scan_end ? S_PASS : S_SCAN;
            S_PASS:  state_next = (hit_reg && is_rsv && !last_pass) ? S_PREP : S_RESP;
            S_HRD:   state_next = S_HCHK;
            S_HCHK:  state_next = S_RESP;
            S_RESP:  state_next = (!out_valid_reg || !out_stall) ? S_IDLE : S_RESP;
            default: state_next = S_IDLE;
        endcase
    end

    // datapath
    always_comb
    begin
        item_next       = item_reg;
        res_next        = res_reg;
        lim_next        = lim_reg;
        cand_next       = cand_reg;
        cand_end_next   = cand_end_reg;
        nxt_next        = nxt_reg;
        hit_next        = hit_reg;
        free_found_next = free_found_reg;
        free_idx_next   = free_idx_reg;
        idx_next        = idx_reg;
        chk_valid_next  = 1'b0;
        chk_idx_next    = chk_idx_reg;
        pass_next       = pass_reg;
        gen_next        = gen_reg;
        out_next        = out_reg;
        out_valid_next  = out_valid_reg && out_stall;
        case (state_reg)
            S_IDLE:
            begin
                if (in_acc)
                begin
                    item_next = in_item;
                    lim_next  = lim_c;
                    pass_next = '0;
                    res_next  = '0;
                    res_next.status = idle_status;
                    if (in_item.func == FN_RESERVE)
                        cand_next = align_up(CW'(start_reg), CW'(in_item.align_bytes));
                    else
                        cand_next = CW'(in_item.base_addr);
                end
            end
            S_PREP:
            begin
                cand_end_next   = cand_reg + len_c;
                nxt_next        = cand_reg;
                hit_next        = 1'b0;
                free_found_next = 1'b0;
                idx_next        = '0;
                res_next.status = is_rsv ? ST_NO_SPACE : ST_INVALID;
            end
            S_SCAN:
            begin
                if (issue)
                begin
                    idx_next       = idx_reg + IW'(1);
                    chk_valid_next = 1'b1;
                    chk_idx_next   = idx_reg[SW-1:0];
                end
                if (chk_valid_reg)
                begin
                    if (chk_kind != K_FREE)
                    begin
                        if ((cand_reg < ent_end) && (CW'(mem_rd_data.base) < cand_end_reg))
                        begin
                            hit_next = 1'b1;
                            if (ent_end > nxt_reg)
                                nxt_next = ent_end;
                        end
                    end
                    else if (!free_found_reg)
                    begin
                        free_found_next = 1'b1;
                        free_idx_next   = chk_idx_reg;
                    end
                end
            end
            S_PASS:
            begin
                if (hit_reg)
                begin
                    cand_next = align_up(nxt_reg, CW'(item_reg.align_bytes));
                    pass_next = pass_reg + PW'(1);
                    res_next.status = is_rsv ? ST_NO_SPACE : ST_INVALID;
                end
                else if (place_ok)
                begin
                    gen_next = gen_reg + 64'd1;
                    res_next.status = ST_OK;
                    if (item_reg.func != FN_EXCLUDE)
                    begin
                        res_next.out_slot = fi9[3:0];
                        res_next.out_gen  = gen_reg;
                        res_next.out_base = cand_reg[47:0];
                    end
                end
                else
                begin
                    res_next.status = ST_NO_SPACE;
                end
            end
            S_HCHK:
            begin
                if (h_kind != K_RESERVED || mem_rd_data.gen != item_reg.handle_gen)
                    res_next.status = ST_NOT_FOUND;
                else if (item_reg.owner_id == 64'd0 || mem_rd_data.owner != item_reg.owner_id)
                    res_next.status = ST_WRONG_OWNER;
                else
                begin
                    res_next.status = ST_OK;
                    if (item_reg.func == FN_INSPECT)
                    begin
                        res_next.out_base   = mem_rd_data.base;
                        res_next.out_length = mem_rd_data.length;
                    end
                end
            end
            S_RESP:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_next       = res_reg;
                    out_valid_next = 1'b1;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            chk_valid_reg <= 1'b0;
            gen_reg       <= 64'd1;
            start_reg     <= 48'd0;
            end_reg       <= 49'h1_0000_0000_0000;
            for (int i = 0; i < SLOTS; i++)
            begin
                kind_reg[i] <= K_FREE;
            end
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            chk_valid_reg <= chk_valid_next;
            gen_reg       <= gen_next;
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == REG_REGION_START)
                    start_reg <= cfg_data[47:0];
                else
                    end_reg <= cfg_data;
            end
            if (mem_wr_en)
                kind_reg[free_idx_reg] <= (item_reg.func == FN_EXCLUDE) ? K_EXCLUDED : K_RESERVED;
            if (state_reg == S_HCHK && res_next.status == ST_OK && item_reg.func == FN_RECLAIM)
                kind_reg[hidx] <= K_FREE;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg       <= item_next;
        res_reg        <= res_next;
        out_reg        <= out_next;
        lim_reg        <= lim_next;
        cand_reg       <= cand_next;
        cand_end_reg   <= cand_end_next;
        nxt_reg        <= nxt_next;
        hit_reg        <= hit_next;
        free_found_reg <= free_found_next;
        free_idx_reg   <= free_idx_next;
        idx_reg        <= idx_next;
        chk_idx_reg    <= chk_idx_next;
        pass_reg       <= pass_next;
    end

`ifndef SYNTHESIS
    a_fail_no_handle: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_reg.status != ST_OK |-> out_reg.out_gen == 64'd0
            && out_reg.out_slot == 4'd0)
        else $error("failed op returned a handle");
    a_gen_step: assert property (@(posedge clk) disable iff (!rst_n)
        gen_reg != $past(gen_reg) |-> gen_reg == $past(gen_reg) + 64'd1)
        else $error("generation counter jumped");
    a_write_free: assert property (@(posedge clk) disable iff (!rst_n)
        mem_wr_en |-> kind_reg[free_idx_reg] == K_FREE)
        else $error("placement overwrote an occupied slot");
`endif

endmodule

// File: tb/testbench.sv
// self-checking testbench for the aligned address range allocator unit
`timescale 1ns / 1ps

module testbench;
    import aara_pkg::*;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    in_item_t    in_item = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    out_item_t   out_item;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [0:0]  cfg_index = REG_REGION_START;
    logic [48:0] cfg_data = '0;

    aligned_address_range_allocator_unit dut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .in_item(in_item),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .out_item(out_item),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    localparam int NSLOTS = 16;
    localparam logic [63:0] PAGE = 64'd4096;
    localparam logic [63:0] ADDR_CAP = 64'h1_0000_0000_0000;

    always #4 clk = ~clk;

    in_item_t  pending_ops[$];
    out_item_t expected_results[$];
    int        errors = 0;
    int        send_idle_pct = 0;
    int        recv_stall_pct = 0;

    kind_t       tbl_kind[NSLOTS];
    logic [63:0] tbl_owner[NSLOTS];
    logic [63:0] tbl_base[NSLOTS];
    logic [63:0] tbl_len[NSLOTS];
    logic [63:0] tbl_gen[NSLOTS];
    logic [63:0] gen_counter;
    logic [63:0] reg_start;
    logic [63:0] reg_end;

    function automatic logic [63:0] rnd64();
        return {$urandom, $urandom};
    endfunction

    function automatic logic [63:0] limit_addr();
        return (reg_end > ADDR_CAP) ? ADDR_CAP : reg_end;
    endfunction

    function automatic bit fits_in(logic [63:0] a, logic [63:0] l, logic [63:0] lim);
        return l != 0 && a < lim && l <= lim - a;
    endfunction

    function automatic bit hits_slot(int i, logic [63:0] a, logic [63:0] l);
        return tbl_kind[i] != K_FREE && a < tbl_base[i] + tbl_len[i] && tbl_base[i] < a + l;
    endfunction

    function automatic bit range_open(logic [63:0] a, logic [63:0] l);
        if (a < reg_start || !fits_in(a, l, limit_addr()) || a % PAGE != 0 || l % PAGE != 0)
            return 0;
        for (int i = 0; i < NSLOTS; i++)
            if (hits_slot(i, a, l))
                return 0;
        return 1;
    endfunction

    function automatic logic [2:0] claim_range(logic [63:0] own, logic [63:0] a,
                                               logic [63:0] l, kind_t k, output int slot);
        slot = 0;
        if (!range_open(a, l))
            return ST_INVALID;
        if (gen_counter == 0 || gen_counter == '1)
            return ST_NO_SPACE;
        for (int i = 0; i < NSLOTS; i++)
        begin
            if (tbl_kind[i] == K_FREE)
            begin
                tbl_kind[i] = k;
                tbl_owner[i] = own;
                tbl_base[i] = a;
                tbl_len[i] = l;
                tbl_gen[i] = gen_counter;
                gen_counter = gen_counter + 1;
                slot = i;
                return ST_OK;
            end
        end
        return ST_NO_SPACE;
    endfunction

    function automatic logic [63:0] round_up(logic [63:0] v, logic [63:0] a);
        return (v + a - 1) & ~(a - 1);
    endfunction

    function automatic logic [2:0] lookup_handle(logic [63:0] own, int hs, logic [63:0] hg);
        if (hg == 0)
            return ST_NOT_FOUND;
        if (tbl_kind[hs] != K_RESERVED || tbl_gen[hs] != hg)
            return ST_NOT_FOUND;
        if (own == 0 || tbl_owner[hs] != own)
            return ST_WRONG_OWNER;
        return ST_OK;
    endfunction

    function automatic out_item_t allocate_result(in_item_t it);
        out_item_t   r;
        logic [2:0]  st;
        int          slot;
        int          hs;
        logic [63:0] len;
        logic [63:0] aln;
        logic [63:0] cand;
        logic [63:0] nxt;
        logic [63:0] lim;
        logic [63:0] obase;
        logic [63:0] olen;
        st = ST_INVALID;
        slot = 0;
        obase = 0;
        olen = 0;
        len = 64'(it.length_bytes);
        aln = 64'(it.align_bytes);
        hs = it.handle_slot;
        case (it.func)
            FN_RESERVE:
            begin
                if (it.owner_id != 0 && len != 0 && len % PAGE == 0 && aln >= PAGE
                    && (aln & (aln - 1)) == 0)
                begin
                    cand = round_up(reg_start, aln);
                    lim = limit_addr();
                    st = ST_NO_SPACE;
                    for (int p = 0; p <= NSLOTS + 1; p++)
                    begin
                        if (!fits_in(cand, len, lim))
                            break;
                        nxt = cand;
                        for (int i = 0; i < NSLOTS; i++)
                            if (hits_slot(i, cand, len) && tbl_base[i] + tbl_len[i] > nxt)
                                nxt = tbl_base[i] + tbl_len[i];
                        if (nxt == cand)
                        begin
                            st = claim_range(it.owner_id, cand, len, K_RESERVED, slot);
                            break;
                        end
                        cand = round_up(nxt, aln);
                    end
                    if (st == ST_OK)
                        obase = cand;
                end
            end
            FN_RESERVE_AT:
            begin
                if (it.owner_id != 0)
                begin
                    st = claim_range(it.owner_id, 64'(it.base_addr), len, K_RESERVED, slot);
                    if (st == ST_OK)
                        obase = 64'(it.base_addr);
                end
            end
            FN_EXCLUDE:
            begin
                st = claim_range(0, 64'(it.base_addr), len, K_EXCLUDED, slot);
                slot = 0;
            end
            FN_RECLAIM:
            begin
                st = lookup_handle(it.owner_id, hs, it.handle_gen);
                if (st == ST_OK)
                begin
                    tbl_kind[hs] = K_FREE;
                    tbl_owner[hs] = 0;
                    tbl_base[hs] = 0;
                    tbl_len[hs] = 0;
                    tbl_gen[hs] = 0;
                end
            end
            FN_INSPECT:
            begin
                st = lookup_handle(it.owner_id, hs, it.handle_gen);
                if (st == ST_OK)
                begin
                    obase = tbl_base[hs];
                    olen = tbl_len[hs];
                end
            end
            default: st = ST_INVALID;
        endcase
        r.status = st;
        r.out_slot = 4'(slot);
        r.out_gen = 0;
        if (st == ST_OK && (it.func == FN_RESERVE || it.func == FN_RESERVE_AT))
            r.out_gen = tbl_gen[slot];
        else
            r.out_slot = 0;
        r.out_base = obase[47:0];
        r.out_length = olen[48:0];
        return r;
    endfunction

    function automatic in_item_t make_op(logic [2:0] f, logic [63:0] own, logic [63:0] b,
                                         logic [63:0] l, logic [63:0] a, int hs,
                                         logic [63:0] hg);
        in_item_t it;
        it.func = f;
        it.owner_id = own;
        it.base_addr = b[47:0];
        it.length_bytes = l[48:0];
        it.align_bytes = a[48:0];
        it.handle_slot = 4'(hs);
        it.handle_gen = hg;
        return it;
    endfunction

    function automatic logic [63:0] pick_owner();
        case ($urandom_range(9))
            0: return rnd64();
            1: return 0;
            default: return 64'($urandom_range(1, 3));
        endcase
    endfunction

    function automatic in_item_t random_op();
        in_item_t    it;
        int          hs;
        int          sel;
        logic [63:0] l;
        logic [63:0] b;
        l = PAGE * $urandom_range(1, 16);
        b = (reg_start & ~(PAGE - 1)) + PAGE * $urandom_range(0, 80);
        if ($urandom_range(9) == 0)
            b = rnd64() & 64'hFFFF_FFFF_F000;
        if ($urandom_range(19) == 0)
            b = b + 64'($urandom_range(1, 4095));
        hs = $urandom_range(NSLOTS - 1);
        sel = $urandom_range(99);
        if (sel < 30)
            it = make_op(FN_RESERVE, pick_owner(), rnd64(), l,
                         PAGE << $urandom_range(0, 5), hs, rnd64());
        else if (sel < 45)
            it = make_op(FN_RESERVE_AT, pick_owner(), b, l, rnd64(), hs, rnd64());
        else if (sel < 55)
            it = make_op(FN_EXCLUDE, pick_owner(), b, l, rnd64(), hs, rnd64());
        else if (sel < 90)
        begin
            it = make_op(($urandom_range(1) != 0) ? FN_RECLAIM : FN_INSPECT, pick_owner(),
                         rnd64(), rnd64(), rnd64(), hs, rnd64());
            if (tbl_kind[hs] != K_FREE && $urandom_range(9) < 8)
            begin
                it.handle_gen = tbl_gen[hs];
                if ($urandom_range(4) != 0)
                    it.owner_id = tbl_owner[hs];
            end
        end
        else
            it = make_op(3'($urandom_range(7)), rnd64(), rnd64(), rnd64(), rnd64(), hs,
                         rnd64());
        return it;
    endfunction

    task automatic queue_op(in_item_t it);
        pending_ops.push_back(it);
        expected_results.push_back(allocate_result(it));
    endtask

    task automatic drain();
        while (pending_ops.size() != 0 || expected_results.size() != 0 || in_valid)
            @(negedge clk);
        repeat (400) @(negedge clk);
    endtask

    task automatic write_reg(logic [0:0] idx, logic [63:0] val);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val[48:0];
        forever
        begin
            @(negedge clk);
            if (cfg_ready)
                break;
        end
        @(posedge clk);
        cfg_valid <= 1'b0;
        if (idx == REG_REGION_START)
            reg_start = val & 64'hFFFF_FFFF_FFFF;
        else
            reg_end = val & 64'h1_FFFF_FFFF_FFFF;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid <= 1'b0;
        else if (!in_valid || !in_stall)
        begin
            if (pending_ops.size() != 0 && $urandom_range(99) >= send_idle_pct)
            begin
                in_item <= pending_ops.pop_front();
                in_valid <= 1'b1;
            end
            else
                in_valid <= 1'b0;
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_stall <= 1'b0;
        else
        begin
            out_stall <= $urandom_range(99) < recv_stall_pct;
            if (out_valid && !out_stall)
            begin
                if (expected_results.size() == 0)
                begin
                    $display("%0t: unexpected transfer %h", $realtime, out_item);
                    errors++;
                end
                else
                begin
                    out_item_t e;
                    e = expected_results.pop_front();
                    if (e.status !== out_item.status)
                        $display("%0t: status exp %0d got %0d", $realtime, e.status,
                                 out_item.status);
                    if (e.out_slot !== out_item.out_slot)
                        $display("%0t: slot exp %0d got %0d", $realtime, e.out_slot,
                                 out_item.out_slot);
                    if (e.out_gen !== out_item.out_gen)
                        $display("%0t: gen exp %h got %h", $realtime, e.out_gen,
                                 out_item.out_gen);
                    if (e.out_base !== out_item.out_base)
                        $display("%0t: base exp %h got %h", $realtime, e.out_base,
                                 out_item.out_base);
                    if (e.out_length !== out_item.out_length)
                        $display("%0t: length exp %h got %h", $realtime, e.out_length,
                                 out_item.out_length);
                    if (e !== out_item)
                        errors++;
                end
            end
        end
    end

    initial
    begin
        #(8ns * 3_000_000);
        $display("Regression FAIL");
        $finish;
    end

    initial
    begin
        logic [63:0] starts[7];
        logic [63:0] ends[7];
        logic [63:0] top;
        top = ADDR_CAP;
        starts = '{64'h0, 64'h1_0000, 64'h0, top - 64'h2_0000, 64'h5000, 64'h1234, 64'h0};
        ends = '{top, 64'h8_0000, 64'h1000, top, 64'h5000, 64'h4_0000, 64'h2_0000};
        for (int i = 0; i < NSLOTS; i++)
        begin
            tbl_kind[i] = K_FREE;
            tbl_owner[i] = 0;
            tbl_base[i] = 0;
            tbl_len[i] = 0;
            tbl_gen[i] = 0;
        end
        gen_counter = 1;
        reg_start = 0;
        reg_end = top;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(negedge clk);

        send_idle_pct = 7;
        recv_stall_pct = 73;
        queue_op(make_op(FN_RESERVE, 1, 0, PAGE, PAGE, 0, 0));
        queue_op(make_op(FN_RESERVE, 2, 0, 64'h3000, 64'h1_0000, 0, 0));
        queue_op(make_op(FN_RESERVE, 1, 0, 0, PAGE, 0, 0));
        queue_op(make_op(FN_RESERVE, 1, 0, 64'h1001, PAGE, 0, 0));
        queue_op(make_op(FN_RESERVE, 1, 0, PAGE, 0, 0, 0));
        queue_op(make_op(FN_RESERVE, 1, 0, PAGE, 64'h3000, 0, 0));
        queue_op(make_op(FN_RESERVE, 1, 0, PAGE, top, 0, 0));
        queue_op(make_op(FN_RESERVE, 0, 0, PAGE, PAGE, 0, 0));
        queue_op(make_op(FN_RESERVE_AT, 3, top - PAGE, PAGE, 0, 0, 0));
        queue_op(make_op(FN_RESERVE_AT, 3, 64'h0, PAGE, 0, 0, 0));
        queue_op(make_op(FN_RESERVE_AT, 3, 64'h2_0000, top, 0, 0, 0));
        queue_op(make_op(FN_EXCLUDE, 0, 64'h2_0000, 64'h2000, 0, 0, 0));
        queue_op(make_op(FN_EXCLUDE, 5, 64'h3_0800, PAGE, 0, 0, 0));
        queue_op(make_op(FN_RESERVE, 2, 0, 64'h2000, 64'h2_0000, 0, 0));
        queue_op(make_op(FN_INSPECT, 1, 0, 0, 0, 0, 1));
        queue_op(make_op(FN_INSPECT, 2, 0, 0, 0, 0, 1));
        queue_op(make_op(FN_RECLAIM, 1, 0, 0, 0, 0, 0));
        queue_op(make_op(FN_RECLAIM, 0, 0, 0, 0, 3, 4));
        queue_op(make_op(FN_RECLAIM, 1, 0, 0, 0, 0, 1));
        queue_op(make_op(FN_INSPECT, 1, 0, 0, 0, 0, 1));
        queue_op(make_op(3'd5, 1, 0, PAGE, PAGE, 0, 1));
        queue_op(make_op(3'd6, 1, 0, PAGE, PAGE, 0, 1));
        queue_op(make_op(3'd7, 1, 0, PAGE, PAGE, 0, 1));
        for (int i = 0; i < NSLOTS; i++)
            queue_op(make_op(FN_RESERVE, 3, 0, PAGE, PAGE, 0, 0));

        for (int ph = 0; ph < 7; ph++)
        begin
            drain();
            if (ph == 3)
            begin
                send_idle_pct = 73;
                recv_stall_pct = 7;
            end
            if (ph == 5)
            begin
                send_idle_pct = 0;
                recv_stall_pct = 0;
            end
            write_reg(REG_REGION_START, starts[ph]);
            write_reg(REG_REGION_END, ends[ph]);
            @(negedge clk);
            for (int n = 0; n < 165; n++)
                queue_op(random_op());
        end
        drain();
        if (errors == 0 && expected_results.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
